[hdl/mcaa_pkg.sv]
// Package for the multichannel converter averager: sizes, codes and payload types.
// No dependencies; every other file in hdl/ refers to it by scoped names.

package mcaa_pkg;

  // Channel count and derived index width (at least one bit)
  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths fixed by the interface
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned AVG_SHIFT  = 5;
  localparam int unsigned AVG_W      = 13;
  localparam int unsigned CHAN_FLD_W = 3;
  localparam int unsigned FACTOR_W   = 8;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(32);
  localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

  // Result queue depth: one entry drains while one is pushed and one is in flight
  localparam int unsigned OUT_DEPTH  = 3;
  localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Function codes of an input transaction
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef logic [CH_W-1:0]  ch_idx_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic                func;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [CHAN_FLD_W-1:0] channel;
    logic [AVG_W-1:0]      average;
    logic                  set_complete;
    logic [CHAN_FLD_W-1:0] next_channel;
  } out_t;

  // Access request to the channel sum store
  typedef struct packed {
    logic    clear;
    logic    re;
    ch_idx_t raddr;
    logic    we;
    ch_idx_t waddr;
    sum_t    wdata;
  } sum_req_t;

  // Low bits of a channel index as carried in the result fields
  function automatic logic [CHAN_FLD_W-1:0] chan_field(ch_idx_t idx);
    logic [CH_W+CHAN_FLD_W-1:0] wide;
    wide = {{CHAN_FLD_W{1'b0}}, idx};
    return wide[CHAN_FLD_W-1:0];
  endfunction

endpackage

[hdl/mcaa_sum_ram.sv]
// Channel sum memory: one write port, one read port, registered read data.
// Depends on mcaa_pkg for depth and word width.

module mcaa_sum_ram (
  input  logic             clk_i,
  input  logic             we_i,
  input  mcaa_pkg::ch_idx_t waddr_i,
  input  mcaa_pkg::sum_t   wdata_i,
  input  logic             re_i,
  input  mcaa_pkg::ch_idx_t raddr_i,
  output mcaa_pkg::sum_t   rdata_o
);

  mcaa_pkg::sum_t mem_q [mcaa_pkg::CHANNELS];
  mcaa_pkg::sum_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mcaa_sum_store.sv]
// Channel sum store: RAM plus per-entry valid bits for the clear command and
// write-to-read forwarding. Depends on mcaa_pkg and mcaa_sum_ram.

module mcaa_sum_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcaa_pkg::sum_req_t req_i,
  output mcaa_pkg::sum_t     rdata_o
);

  logic [mcaa_pkg::CHANNELS-1:0] valid_q, valid_d;
  logic                          vld_rd_q;
  logic                          fwd_q;
  mcaa_pkg::sum_t                fwd_data_q;
  mcaa_pkg::sum_t                ram_rdata;

  mcaa_sum_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  // Set on write, drop all on clear (clear wins over a same-cycle write)
  always_comb begin
    valid_d = valid_q;
    if (req_i.we) begin
      valid_d[req_i.waddr] = 1'b1;
    end
    if (req_i.clear) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (req_i.re) begin
        vld_rd_q <= valid_q[req_i.raddr];
        fwd_q    <= req_i.we && (req_i.waddr == req_i.raddr);
      end
    end
  end

  // Capture write data that the RAM read misses at the same edge
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      fwd_data_q <= req_i.wdata;
    end
  end

  // Forwarded data first, then RAM data if the entry was written since clear
  always_comb begin
    if (fwd_q) begin
      rdata_o = fwd_data_q;
    end else if (vld_rd_q) begin
      rdata_o = ram_rdata;
    end else begin
      rdata_o = '0;
    end
  end

endmodule

[hdl/mcaa_out_fifo.sv]
// Result queue: small register FIFO between the accumulate stage and the output.
// Depends on mcaa_pkg for the result type and depth.

module mcaa_out_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  mcaa_pkg::out_t                     data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output mcaa_pkg::out_t                     data_o,
  output logic [mcaa_pkg::OUT_CNT_W-1:0]     count_o
);

  mcaa_pkg::out_t                     mem_q [mcaa_pkg::OUT_DEPTH];
  logic [mcaa_pkg::OUT_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [mcaa_pkg::OUT_CNT_W-1:0]     cnt_q;
  logic                               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // Store pushed result
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == mcaa_pkg::OUT_PTR_W'(mcaa_pkg::OUT_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == mcaa_pkg::OUT_PTR_W'(mcaa_pkg::OUT_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/multichannel_adc_averager.sv]
// Top level of the multichannel converter averager: control, accumulate stage.
// Depends on mcaa_pkg, mcaa_sum_store and mcaa_out_fifo.

// One input transaction is taken per clock cycle while input ready is high. A
// sample transaction reads the current channel's sum from the sum memory at
// acceptance, and in the next cycle the accumulate stage adds the sample
// (saturating at 2^18-1) and writes the sum back; a write and a read of the
// same channel in the same cycle are forwarded, so back-to-back samples see
// each other. When the sample count equals average_factor, that stage also
// produces a result (sum >> 5, channel, wrap flag, next channel), which passes
// from the stage register into a three-entry queue before the output, so a
// result on every sample still flows at one per cycle while the output side is
// ready. A clear transaction empties all sums at once through per-channel valid
// bits and yields no result. Input ready drops only while the result queue
// could overflow.

module multichannel_adc_averager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcaa_pkg::FACTOR_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mcaa_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mcaa_pkg::out_t                 out_data_o
);

  logic [mcaa_pkg::FACTOR_W-1:0]  factor_q;
  logic [mcaa_pkg::FACTOR_W-1:0]  count_q, count_d;
  mcaa_pkg::ch_idx_t              cur_ch_q, cur_ch_d;

  logic                           in_acc;
  logic                           is_sample;
  logic                           is_clear;
  logic                           emit;
  logic                           last_ch;
  mcaa_pkg::ch_idx_t              next_ch;

  // Accumulate stage registers
  logic                           b_valid_q;
  logic                           b_emit_q;
  mcaa_pkg::ch_idx_t              b_wr_ch_q;
  mcaa_pkg::ch_idx_t              b_out_ch_q;
  logic                           b_wrap_q;
  logic [mcaa_pkg::SAMPLE_W-1:0]  b_smp_q;

  mcaa_pkg::sum_req_t             req;
  mcaa_pkg::sum_t                 old_sum;
  logic [mcaa_pkg::SUM_W:0]       add_sum;
  mcaa_pkg::sum_t                 new_sum;
  mcaa_pkg::out_t                 res;
  logic                           push;
  logic [mcaa_pkg::OUT_CNT_W-1:0] q_cnt;
  logic [mcaa_pkg::OUT_CNT_W:0]   q_need;

  // Handshake: reserve queue space for the result in flight
  assign q_need     = {1'b0, q_cnt} + (mcaa_pkg::OUT_CNT_W+1)'(b_valid_q && b_emit_q);
  assign in_ready_o = (q_need < (mcaa_pkg::OUT_CNT_W+1)'(mcaa_pkg::OUT_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_sample  = in_acc && (in_data_i.func == mcaa_pkg::FUNC_SAMPLE);
  assign is_clear   = in_acc && (in_data_i.func == mcaa_pkg::FUNC_CLEAR);

  // Decide emission and channel advance at acceptance
  assign emit    = (count_q == factor_q);
  assign last_ch = (cur_ch_q == mcaa_pkg::CH_W'(mcaa_pkg::CHANNELS - 1));
  assign next_ch = last_ch ? '0 : cur_ch_q + 1'b1;

  always_comb begin
    count_d  = count_q;
    cur_ch_d = cur_ch_q;
    if (is_clear) begin
      count_d  = '0;
      cur_ch_d = '0;
    end else if (is_sample) begin
      if (emit) begin
        count_d  = mcaa_pkg::FACTOR_W'(1);
        cur_ch_d = next_ch;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // Hold configuration and sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= mcaa_pkg::FACTOR_RST;
      count_q  <= '0;
      cur_ch_q <= '0;
    end else begin
      if (cfg_we_i) begin
        factor_q <= cfg_data_i;
      end
      count_q  <= count_d;
      cur_ch_q <= cur_ch_d;
    end
  end

  // Advance a sample into the accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_emit_q  <= 1'b0;
    end else begin
      b_valid_q <= is_sample;
      b_emit_q  <= is_sample && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      b_wr_ch_q  <= emit ? next_ch : cur_ch_q;
      b_out_ch_q <= cur_ch_q;
      b_wrap_q   <= last_ch;
      b_smp_q    <= in_data_i.sample;
    end
  end

  // Add with saturation; on emission the new channel's sum starts from zero,
  // since the stored sum of that channel is ignored and only the sample is written
  assign add_sum = {1'b0, old_sum} + (mcaa_pkg::SUM_W+1)'(b_smp_q);

  always_comb begin
    if (b_emit_q) begin
      new_sum = mcaa_pkg::SUM_W'(b_smp_q);
    end else if (add_sum > {1'b0, mcaa_pkg::SUM_MAX}) begin
      new_sum = mcaa_pkg::SUM_MAX;
    end else begin
      new_sum = add_sum[mcaa_pkg::SUM_W-1:0];
    end
  end

  // Sum memory access: read at acceptance, write back from the stage
  always_comb begin
    req.clear = is_clear;
    req.re    = is_sample;
    req.raddr = cur_ch_q;
    req.we    = b_valid_q;
    req.waddr = b_wr_ch_q;
    req.wdata = new_sum;
  end

  mcaa_sum_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (old_sum)
  );

  // Build the result transaction
  always_comb begin
    res.channel      = mcaa_pkg::chan_field(b_out_ch_q);
    res.average      = old_sum[mcaa_pkg::AVG_SHIFT +: mcaa_pkg::AVG_W];
    res.set_complete = b_wrap_q;
    res.next_channel = mcaa_pkg::chan_field(b_wr_ch_q);
  end

  assign push = b_valid_q && b_emit_q;

  mcaa_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o),
    .count_o (q_cnt)
  );

endmodule

[tb/tb.sv]
// Testbench for multichannel_adc_averager: random and directed sample streams
// with a per-channel average predictor. Depends on mcaa_pkg and the hdl/ sources.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_PCT       = 8;

  // Running model of the per-channel sums; queues the averages it predicts
  class average_tracker;
    mcaa_pkg::sum_t                chan_sum [mcaa_pkg::CHANNELS];
    logic [mcaa_pkg::FACTOR_W-1:0] sample_cnt;
    int unsigned                   cur_chan;
    logic [mcaa_pkg::FACTOR_W-1:0] factor;
    mcaa_pkg::out_t                pending_avg [$];
    int unsigned                   mismatches;
    int unsigned                   averages_seen;

    function new();
      clear_all();
      factor        = mcaa_pkg::FACTOR_RST;
      mismatches    = 0;
      averages_seen = 0;
    endfunction

    function void clear_all();
      foreach (chan_sum[i]) chan_sum[i] = '0;
      sample_cnt = '0;
      cur_chan   = 0;
    endfunction

    function int unsigned pending();
      return pending_avg.size();
    endfunction

    // Update the sums for one accepted transaction; queue an average when a channel closes
    function void take_sample(mcaa_pkg::in_t item);
      mcaa_pkg::out_t           avg;
      logic [mcaa_pkg::SUM_W:0] acc;
      if (item.func == mcaa_pkg::FUNC_CLEAR) begin
        clear_all();
        return;
      end
      if (cur_chan >= mcaa_pkg::CHANNELS) cur_chan = 0;
      if (sample_cnt == factor) begin
        avg.channel        = mcaa_pkg::CHAN_FLD_W'(cur_chan);
        avg.average        = mcaa_pkg::AVG_W'(chan_sum[cur_chan] >> mcaa_pkg::AVG_SHIFT);
        chan_sum[cur_chan] = '0;
        sample_cnt         = '0;
        if (cur_chan + 1 >= mcaa_pkg::CHANNELS) begin
          cur_chan         = 0;
          avg.set_complete = 1'b1;
        end else begin
          cur_chan         = cur_chan + 1;
          avg.set_complete = 1'b0;
        end
        avg.next_channel = mcaa_pkg::CHAN_FLD_W'(cur_chan);
        pending_avg.push_back(avg);
      end
      sample_cnt = sample_cnt + 1'b1;
      // Saturate rather than wrap
      acc = {1'b0, chan_sum[cur_chan]} + (mcaa_pkg::SUM_W+1)'(item.sample);
      if (acc > {1'b0, mcaa_pkg::SUM_MAX}) acc = {1'b0, mcaa_pkg::SUM_MAX};
      chan_sum[cur_chan] = acc[mcaa_pkg::SUM_W-1:0];
    endfunction

    // Compare one accepted output transaction with the oldest predicted average
    function void compare_average(mcaa_pkg::out_t got);
      mcaa_pkg::out_t want;
      if (pending_avg.size() == 0) begin
        $error("unexpected average: channel %0d average %0d", got.channel, got.average);
        mismatches++;
        return;
      end
      want = pending_avg.pop_front();
      averages_seen++;
      if (got.channel !== want.channel) begin
        $error("channel: expected %0d, got %0d", want.channel, got.channel);
        mismatches++;
      end
      if (got.average !== want.average) begin
        $error("average: expected %0d, got %0d", want.average, got.average);
        mismatches++;
      end
      if (got.set_complete !== want.set_complete) begin
        $error("set_complete: expected %0b, got %0b", want.set_complete, got.set_complete);
        mismatches++;
      end
      if (got.next_channel !== want.next_channel) begin
        $error("next_channel: expected %0d, got %0d", want.next_channel, got.next_channel);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [mcaa_pkg::FACTOR_W-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  mcaa_pkg::in_t                 in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  mcaa_pkg::out_t                out_data_o;

  average_tracker tracker = new();
  bit             idle_on = 1'b1;
  int unsigned    n_samples_sent;
  int unsigned    n_settings;

  multichannel_adc_averager u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stall the result side at random, except during the no-idle stretch
  always @(negedge clk_i) begin
    out_ready_i <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // Check every output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.compare_average(out_data_o);
  end

  // Abort when no transaction moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic mcaa_pkg::in_t mk_item(logic func,
                                            logic [mcaa_pkg::SAMPLE_W-1:0] sample);
    mcaa_pkg::in_t item;
    item.func   = func;
    item.sample = sample;
    return item;
  endfunction

  // Bias toward the extremes of the converter range
  function automatic logic [mcaa_pkg::SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return mcaa_pkg::SAMPLE_W'($urandom);
  endfunction

  // Offer one transaction, hold it until accepted, then predict
  task automatic send_item(input mcaa_pkg::in_t item);
    @(negedge clk_i);
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_sample(item);
    n_samples_sent++;
  endtask

  // Drop valid and wait for every predicted average, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the averaging factor while the block is idle
  task automatic retune(input logic [mcaa_pkg::FACTOR_W-1:0] f);
    drain_results();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= f;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.factor = f;
    n_settings++;
  endtask

  // Random samples with occasional clears and occasional full drains
  task automatic run_phase(input int unsigned n, input int unsigned clear_pct);
    mcaa_pkg::in_t item;
    repeat (n) begin
      if ($urandom_range(199) == 0) drain_results();
      item.func   = ($urandom_range(99) < clear_pct) ? mcaa_pkg::FUNC_CLEAR
                                                      : mcaa_pkg::FUNC_SAMPLE;
      item.sample = rand_sample();
      send_item(item);
    end
  endtask

  initial begin
    logic [mcaa_pkg::SAMPLE_W-1:0] corner_vals [10];
    corner_vals = '{10'h3FF, 10'h000, 10'h3FF, 10'h200, 10'h155,
                    10'h2AA, 10'h001, 10'h3FF, 10'h3FF, 10'h3FF};
    n_samples_sent = 0;
    n_settings     = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Run at the reset factor first
    run_phase(40, 0);

    // Factor one: every sample closes a channel, walk past the wrap
    retune(8'd1);
    foreach (corner_vals[i]) send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, corner_vals[i]));
    send_item(mk_item(mcaa_pkg::FUNC_CLEAR, 10'h3FF));
    send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'd5));
    send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'd7));
    send_item(mk_item(mcaa_pkg::FUNC_CLEAR, 10'h000));

    // Factor zero: emit right after a clear
    retune(8'd0);
    send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'h3FF));
    send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'h3FF));
    send_item(mk_item(mcaa_pkg::FUNC_CLEAR, 10'h155));
    send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'h000));

    // Drop the factor below the count so it wraps; full-scale samples saturate the sum
    retune(8'd20);
    send_item(mk_item(mcaa_pkg::FUNC_CLEAR, 10'h000));
    repeat (15) send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'h3FF));
    retune(8'd5);
    repeat (266) send_item(mk_item(mcaa_pkg::FUNC_SAMPLE, 10'h3FF));
    run_phase(20, 0);

    // Random phases across several factors
    retune(8'd3);
    run_phase(40, 3);
    retune(8'd255);
    run_phase(260, 0);
    retune(8'd2);
    run_phase(40, 3);

    // Stretch without idling on either side
    idle_on = 1'b0;
    retune(8'd1);
    run_phase(80, 3);
    idle_on = 1'b1;

    // Factor zero across a full counter wrap
    retune(8'd0);
    send_item(mk_item(mcaa_pkg::FUNC_CLEAR, rand_sample()));
    run_phase(260, 0);

    retune(8'd7);
    run_phase(40, 3);
    retune(mcaa_pkg::FACTOR_W'($urandom_range(1, 12)));
    run_phase(40, 3);
    retune(8'd4);
    run_phase(40, 4);

    drain_results();
    $display("tb: sent %0d input transactions, checked %0d averages over %0d factor settings",
             n_samples_sent, tracker.averages_seen, n_settings);
    $display("tb: covered clears, factor zero, counter wrap, sum saturation and channel wrap");
    if (tracker.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
